/* hw/rtl/obm_pkg.sv */
package obm_pkg;

    localparam int TABLE_SLOTS_DEF = 256;

    localparam int KEY_W   = 32;
    localparam int OFF_W   = 32;
    localparam int TAG_W   = 8;
    localparam int BYTES_W = 3;

    // Slave word: object_key, current_offset
    localparam int S_DATA_W  = KEY_W + OFF_W;
    localparam int S_KEY_LSB = 0;
    localparam int S_OFF_LSB = KEY_W;

    // Master word: needs_packing, tag_byte, ref_offset, ref_bytes, table_full
    localparam int M_FIELD_W = 1 + TAG_W + OFF_W + BYTES_W + 1;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_DATA_W - M_FIELD_W;
    localparam int M_NP_BIT  = 0;
    localparam int M_TAG_LSB = 1;
    localparam int M_OFF_LSB = M_TAG_LSB + TAG_W;
    localparam int M_BYT_LSB = M_OFF_LSB + OFF_W;
    localparam int M_FULL_BIT = M_BYT_LSB + BYTES_W;

    localparam logic [TAG_W-1:0] TAG_NONE  = 8'd0;
    localparam logic [TAG_W-1:0] TAG_SHORT = 8'd79;  // 'O'
    localparam logic [TAG_W-1:0] TAG_LONG  = 8'd81;  // 'Q'

    localparam logic [BYTES_W-1:0] BYTES_NONE  = 3'd0;
    localparam logic [BYTES_W-1:0] BYTES_SHORT = 3'd2;
    localparam logic [BYTES_W-1:0] BYTES_LONG  = 3'd4;

    localparam logic [OFF_W-1:0] SHORT_LIMIT = 32'h0000_FFFF;

    // Control part of the probe token that walks the cell row
    typedef struct packed {
        logic vld;    // token present in this stage
        logic found;  // a candidate slot has been seen
        logic wrap;   // candidate lies below the start slot
        logic match;  // candidate holds the key (else it is free)
    } tok_ctl_t;

endpackage

/* hw/rtl/obm_cell.sv */
module obm_cell
    import obm_pkg::*;
#(
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] key,
    input  logic [IDX_W-1:0] hash,
    input  tok_ctl_t         ctl_in,
    input  logic [IDX_W-1:0] idx_in,
    input  logic [OFF_W-1:0] off_in,
    output tok_ctl_t         ctl_out,
    output logic [IDX_W-1:0] idx_out,
    output logic [OFF_W-1:0] off_out,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [KEY_W-1:0] wr_key,
    input  logic [OFF_W-1:0] wr_off
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic             slot_valid_reg;
    logic [KEY_W-1:0] slot_key_reg;
    logic [OFF_W-1:0] slot_off_reg;

    tok_ctl_t         ctl_reg, ctl_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [OFF_W-1:0] off_reg, off_next;

    logic hit;
    logic take;
    logic wr_sel;

    // A free slot or a slot with the key ends the probe here
    assign hit  = !slot_valid_reg || (slot_key_reg == key);
    // Take the first hit; a hit at or above the start slot beats a wrapped one
    assign take = ctl_in.vld && hit &&
                  (!ctl_in.found || (ctl_in.wrap && (MY_IDX >= hash)));

    always_comb
    begin
        ctl_next = ctl_in;
        idx_next = idx_in;
        off_next = off_in;
        if (take)
        begin
            ctl_next.found = 1'b1;
            ctl_next.wrap  = (MY_IDX < hash);
            ctl_next.match = slot_valid_reg;
            idx_next       = MY_IDX;
            off_next       = slot_off_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        off_reg <= off_next;
    end

    assign wr_sel = wr_en && (wr_idx == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else if (wr_sel)
        begin
            slot_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            slot_key_reg <= wr_key;
            slot_off_reg <= wr_off;
        end
    end

    assign ctl_out = ctl_reg;
    assign idx_out = idx_reg;
    assign off_out = off_reg;

endmodule

/* hw/rtl/object_backref_memo_table.sv */
// Flow: an accepted word walks its token through the cell row from a start slot that is
//   the key's low bits for a power-of-two slot count, else a reciprocal-multiply key modulo.
//   The block takes no new input word until the last result word is loaded for output;
//   an unread result word holds off the next input word.
// Reset: rst_n clears all slot valid bits, the walking token, the state and the
//   output valid at once; the block takes a word right after reset.
module object_backref_memo_table
    import obm_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // object_key, current_offset
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // needs_packing, tag_byte, ref_offset,
                                          // ref_bytes, table_full, zero pad
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam int PROD_W = 2 * KEY_W + 1;
    // floor(2^(KEY_W+IDX_W) / TABLE_SLOTS): quotient estimate is exact or one low
    localparam logic [KEY_W:0] RECIP =
        (KEY_W + 1)'((PROD_W'(1) << (KEY_W + IDX_W)) / TABLE_SLOTS);
    localparam logic [KEY_W-1:0] SLOTS_K = KEY_W'(TABLE_SLOTS);
    localparam logic [1:0] MOD_LAST = 2'd2;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_MOD     = 2'd1;
    localparam logic [1:0] ST_WALK    = 2'd2;
    localparam logic [1:0] ST_RESOLVE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [OFF_W-1:0]    cur_off_reg, cur_off_next;
    logic [IDX_W-1:0]    hash_reg, hash_next;
    logic [KEY_W-1:0]    quo_reg, quo_next;
    logic [KEY_W-1:0]    qn_reg, qn_next;
    logic [1:0]          mod_step_reg, mod_step_next;
    logic                launch_reg, launch_next;
    logic [M_DATA_W-1:0] res_reg, res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [PROD_W-1:0]   mod_prod;
    logic [PROD_W-1:0]   mod_quo;
    logic [KEY_W-1:0]    mod_rem;
    logic [KEY_W-1:0]    mod_fix;
    logic                out_load;

    // Probe token chain: element 0 is the launch, element i+1 leaves cell i
    tok_ctl_t            launch_ctl;
    tok_ctl_t            ctl_chain [TABLE_SLOTS+1];
    logic [IDX_W-1:0]    idx_chain [TABLE_SLOTS+1];
    logic [OFF_W-1:0]    off_chain [TABLE_SLOTS+1];

    tok_ctl_t            ex_ctl;
    logic [IDX_W-1:0]    ex_idx;
    logic [OFF_W-1:0]    ex_off;

    logic                wr_en;

    logic                r_np;
    logic [TAG_W-1:0]    r_tag;
    logic [OFF_W-1:0]    r_off;
    logic [BYTES_W-1:0]  r_bytes;
    logic                r_full;

    // Key modulo for other slot counts: quotient by reciprocal multiply, back-multiply,
    // then subtract with one correction step; one stage per cycle
    assign mod_prod = PROD_W'(key_reg) * PROD_W'(RECIP);
    assign mod_quo  = mod_prod >> (KEY_W + IDX_W);
    assign mod_rem  = key_reg - qn_reg;
    assign mod_fix  = (mod_rem >= SLOTS_K) ? (mod_rem - SLOTS_K) : mod_rem;

    // Launch a fresh token into cell 0; key and start slot are broadcast
    always_comb
    begin
        launch_ctl     = '0;
        launch_ctl.vld = launch_reg;
    end

    assign ctl_chain[0] = launch_ctl;
    assign idx_chain[0] = '0;
    assign off_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++)
        begin : g_cell
            obm_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .key     (key_reg),
                .hash    (hash_reg),
                .ctl_in  (ctl_chain[g]),
                .idx_in  (idx_chain[g]),
                .off_in  (off_chain[g]),
                .ctl_out (ctl_chain[g+1]),
                .idx_out (idx_chain[g+1]),
                .off_out (off_chain[g+1]),
                .wr_en   (wr_en),
                .wr_idx  (ex_idx),
                .wr_key  (key_reg),
                .wr_off  (cur_off_reg)
            );
        end
    endgenerate

    assign ex_ctl = ctl_chain[TABLE_SLOTS];
    assign ex_idx = idx_chain[TABLE_SLOTS];
    assign ex_off = off_chain[TABLE_SLOTS];

    // Insert into the free slot the token picked, in the cycle it leaves the row
    assign wr_en = (state_reg == ST_WALK) && ex_ctl.vld && ex_ctl.found && !ex_ctl.match;

    // Decode the finished token into a result word
    always_comb
    begin
        r_np    = 1'b1;
        r_tag   = TAG_NONE;
        r_off   = '0;
        r_bytes = BYTES_NONE;
        r_full  = !ex_ctl.found;
        if (ex_ctl.found && ex_ctl.match)
        begin
            r_np  = 1'b0;
            r_off = ex_off;
            if (ex_off <= SHORT_LIMIT)
            begin
                r_tag   = TAG_SHORT;
                r_bytes = BYTES_SHORT;
            end
            else
            begin
                r_tag   = TAG_LONG;
                r_bytes = BYTES_LONG;
            end
        end
    end

    assign out_load = (state_reg == ST_RESOLVE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        cur_off_next  = cur_off_reg;
        hash_next     = hash_reg;
        quo_next      = quo_reg;
        qn_next       = qn_reg;
        mod_step_next = mod_step_reg;
        launch_next   = 1'b0;
        res_next      = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next      = s_tdata[S_KEY_LSB +: KEY_W];
                    cur_off_next  = s_tdata[S_OFF_LSB +: OFF_W];
                    mod_step_next = '0;
                    if (IS_POW2)
                    begin
                        hash_next   = s_tdata[S_KEY_LSB +: IDX_W];
                        launch_next = 1'b1;
                        state_next  = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                // Key is held, so each stage settles in the cycle after the one before
                quo_next      = mod_quo[KEY_W-1:0];
                qn_next       = quo_reg * SLOTS_K;
                mod_step_next = mod_step_reg + 2'd1;
                if (mod_step_reg == MOD_LAST)
                begin
                    hash_next   = mod_fix[IDX_W-1:0];
                    launch_next = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // Hold until the token comes out of the last cell
                if (ex_ctl.vld)
                begin
                    res_next = {{M_PAD_W{1'b0}}, r_full, r_bytes, r_off, r_tag, r_np};
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            launch_reg   <= 1'b0;
            mod_step_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launch_reg   <= launch_next;
            mod_step_reg <= mod_step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        cur_off_reg <= cur_off_next;
        hash_reg    <= hash_next;
        quo_reg     <= quo_next;
        qn_reg      <= qn_next;
        res_reg     <= res_next;
        if (out_load)
        begin
            m_tdata_reg <= res_reg;
        end
    end

    // Accept only when no lookup is in progress
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hw/rtl/obm_check.sv */
module obm_check
    import obm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic               np;
    logic [TAG_W-1:0]   tag;
    logic [OFF_W-1:0]   roff;
    logic [BYTES_W-1:0] rbytes;
    logic               full;

    assign np     = m_tdata[M_NP_BIT];
    assign tag    = m_tdata[M_TAG_LSB +: TAG_W];
    assign roff   = m_tdata[M_OFF_LSB +: OFF_W];
    assign rbytes = m_tdata[M_BYT_LSB +: BYTES_W];
    assign full   = m_tdata[M_FULL_BIT];

    // One lookup at a time: an accepted word closes the input for a while
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a lookup is in progress");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    a_new_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && np) |-> (tag == TAG_NONE && rbytes == BYTES_NONE && roff == '0))
        else $error("packing result carries a reference");

    a_ref_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !np) |->
            (!full && ((tag == TAG_SHORT && rbytes == BYTES_SHORT && roff <= SHORT_LIMIT) ||
                       (tag == TAG_LONG && rbytes == BYTES_LONG && roff > SHORT_LIMIT))))
        else $error("back-reference tag, size and offset disagree");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && full) |-> np)
        else $error("table full flagged on a found key");

endmodule

bind object_backref_memo_table obm_check u_obm_check (.*);

/* tb/sv/object_backref_memo_table_test.sv */
module object_backref_memo_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import obm_pkg::*;

    localparam int SLOTS         = TABLE_SLOTS_DEF;
    localparam int IDLE_PCT      = 7;
    // One word walks the whole cell row, plus the modulo stages for other slot counts.
    localparam int SETTLE_CYCLES = SLOTS + 40;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        logic               needs_packing;
        logic [TAG_W-1:0]   tag_byte;
        logic [OFF_W-1:0]   ref_offset;
        logic [BYTES_W-1:0] ref_bytes;
        logic               table_full;
    } backref_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Own copy of the memo table
    logic [KEY_W-1:0] memo_keys    [SLOTS];
    logic [OFF_W-1:0] memo_offsets [SLOTS];
    logic             memo_valid   [SLOTS];
    int               memo_used;

    backref_t         pending_results[$];
    logic [KEY_W-1:0] packed_keys[$];

    logic calm       = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   cycles     = 0;

    object_backref_memo_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Look the key up with linear probing; insert it when absent and a slot is free.
    function automatic backref_t memo_lookup(input logic [KEY_W-1:0] key,
                                             input logic [OFF_W-1:0] offset);
        backref_t    r;
        int unsigned pos;
        r.needs_packing = 1'b0;
        r.tag_byte      = TAG_NONE;
        r.ref_offset    = '0;
        r.ref_bytes     = BYTES_NONE;
        r.table_full    = 1'b0;
        pos = key % SLOTS;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!memo_valid[pos])
            begin
                memo_valid[pos]   = 1'b1;
                memo_keys[pos]    = key;
                memo_offsets[pos] = offset;
                memo_used++;
                r.needs_packing = 1'b1;
                return r;
            end
            if (memo_keys[pos] == key)
            begin
                r.ref_offset = memo_offsets[pos];
                if (memo_offsets[pos] <= SHORT_LIMIT)
                begin
                    r.tag_byte  = TAG_SHORT;
                    r.ref_bytes = BYTES_SHORT;
                end
                else
                begin
                    r.tag_byte  = TAG_LONG;
                    r.ref_bytes = BYTES_LONG;
                end
                return r;
            end
            pos = (pos + 1) % SLOTS;
        end
        // Key absent and every slot taken: record nothing.
        r.needs_packing = 1'b1;
        r.table_full    = 1'b1;
        return r;
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        logic [OFF_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 32'h0000_FFFF);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_FFFF;
                    2: v = 32'h0001_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] pick_packed_key();
        return packed_keys[$urandom_range(0, packed_keys.size() - 1)];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    // Present one word, hold it until accepted, then predict its result.
    task automatic send_object(input logic [KEY_W-1:0] key, input logic [OFF_W-1:0] offset);
        logic [S_DATA_W-1:0] word;
        backref_t            want;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        word = '0;
        word[S_KEY_LSB +: KEY_W] = key;
        word[S_OFF_LSB +: OFF_W] = offset;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = memo_lookup(key, offset);
        pending_results.push_back(want);
        if (want.needs_packing && !want.table_full)
            packed_keys.push_back(key);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Boundary keys and offsets, then hits on each of them.
    task automatic test_key_extremes();
        send_object(32'h0000_0000, 32'h0000_0000);
        send_object(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_object(32'h8000_0080, 32'h0000_FFFF);
        send_object(32'h0000_0001, 32'h0001_0000);
        send_object(32'h0000_0000, 32'h0000_1234);   // zero key, zero stored offset
        send_object(32'hFFFF_FFFF, 32'h0000_0005);   // long reference, all ones
        send_object(32'h8000_0080, 32'hFFFF_FFFF);   // short limit exactly
        send_object(32'h0000_0001, 32'h0000_0000);   // just past the short limit
    endtask

    // Collisions on occupied home slots, including a wrap past the last slot.
    task automatic test_probe_chains();
        send_object(32'h0000_0100, 32'h0000_0010);
        send_object(32'h0000_01FF, 32'h0000_0020);
        send_object(32'h0000_02FF, 32'hFFFF_0000);
        send_object(32'h0000_0200, 32'h0000_0007);
        send_object(32'h0000_02FF, 32'h0000_0001);
        send_object(32'h0000_01FF, 32'h0000_0002);
        send_object(32'h0000_0100, 32'h0000_0003);
        send_object(32'h0000_0200, 32'h0000_0004);
        send_object(32'h0000_0000, 32'h0000_0005);
    endtask

    // Mix of new objects, repeated objects and keys near zero.
    task automatic test_random_traffic();
        logic [KEY_W-1:0] key;
        int               pick;
        for (int i = 0; i < 640; i++)
        begin
            calm = (i >= 150 && i < 300);
            if (i == 320)
                drain_results();
            pick = $urandom_range(0, 99);
            key  = $urandom;
            if (pick < 25)
            begin
                // Cluster half the new keys on low home slots to grow long chains.
                if ($urandom_range(0, 1))
                    key[7:0] = 8'($urandom_range(0, 23));
            end
            else if (pick < 90)
            begin
                if (packed_keys.size() != 0)
                    key = pick_packed_key();
            end
            else
                key = {24'($urandom_range(0, 3)), 8'($urandom)};
            send_object(key, pick_offset());
        end
        calm = 1'b0;
    endtask

    // Fill the remaining slots, then keep hitting and missing a full table.
    task automatic test_full_table();
        while (memo_used < SLOTS)
            send_object($urandom, pick_offset());
        for (int i = 0; i < 480; i++)
        begin
            if ($urandom_range(0, 1))
                send_object(pick_packed_key(), pick_offset());
            else
                send_object($urandom, pick_offset());
        end
    endtask

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        backref_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[M_NP_BIT] !== want.needs_packing)
                    report_mismatch("needs_packing", 32'(m_tdata[M_NP_BIT]),
                                    32'(want.needs_packing));
                if (m_tdata[M_TAG_LSB +: TAG_W] !== want.tag_byte)
                    report_mismatch("tag_byte", 32'(m_tdata[M_TAG_LSB +: TAG_W]),
                                    32'(want.tag_byte));
                if (m_tdata[M_OFF_LSB +: OFF_W] !== want.ref_offset)
                    report_mismatch("ref_offset", m_tdata[M_OFF_LSB +: OFF_W],
                                    want.ref_offset);
                if (m_tdata[M_BYT_LSB +: BYTES_W] !== want.ref_bytes)
                    report_mismatch("ref_bytes", 32'(m_tdata[M_BYT_LSB +: BYTES_W]),
                                    32'(want.ref_bytes));
                if (m_tdata[M_FULL_BIT] !== want.table_full)
                    report_mismatch("table_full", 32'(m_tdata[M_FULL_BIT]),
                                    32'(want.table_full));
                if (m_tdata[M_FULL_BIT + 1 +: M_PAD_W] !== '0)
                    report_mismatch("pad", 32'(m_tdata[M_FULL_BIT + 1 +: M_PAD_W]), 32'h0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            memo_valid[i] = 1'b0;
        memo_used = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_key_extremes();
        test_probe_chains();
        test_random_traffic();
        test_full_table();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
